// ----- sv/spsp_pkg.sv -----
// Shared constants and types for the sprite screen projection block.
package spsp_pkg;

	localparam int DEF_DISP_W = 1024;
	localparam int DEF_DISP_H = 1024;

	// Quotient bits produced by each divider; results saturate below this.
	localparam int DIV_QW = 24;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAM_POS_X    = 3'd0,
		REG_CAM_POS_Y    = 3'd1,
		REG_CAM_DIR_X    = 3'd2,
		REG_CAM_DIR_Y    = 3'd3,
		REG_CAM_PLANE_X  = 3'd4,
		REG_CAM_PLANE_Y  = 3'd5,
		REG_HEIGHT_SCALE = 3'd6,
		REG_WIDTH_SCALE  = 3'd7
	} cfg_reg_t;

	localparam logic [15:0] RST_CAM_POS_X    = 16'd0;
	localparam logic [15:0] RST_CAM_POS_Y    = 16'd0;
	localparam logic [15:0] RST_CAM_DIR_X    = 16'd16384;
	localparam logic [15:0] RST_CAM_DIR_Y    = 16'd0;
	localparam logic [15:0] RST_CAM_PLANE_X  = 16'd0;
	localparam logic [15:0] RST_CAM_PLANE_Y  = 16'd10813;
	localparam logic [15:0] RST_HEIGHT_SCALE = 16'd4096;
	localparam logic [15:0] RST_WIDTH_SCALE  = 16'd4096;

endpackage

// ----- sv/spsp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, overflow flag.
module spsp_div #(
	parameter int NW = 48,
	parameter int DW = 34,
	parameter int QW = 24
) (
	input  logic          clk,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          ovf
);
	import spsp_pkg::*;

	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	logic [RW-1:0] rem_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic          ovf_s [QW+1];

	// entry stage: quotient would not fit, or divide by zero
	always_ff @(posedge clk) begin
		rem_s[0] <= RW'(num);
		den_s[0] <= den;
		quo_s[0] <= '0;
		ovf_s[0] <= (den == '0) || (RW'(num) >= (RW'(den) << QW));
	end

	for (genvar k = 0; k < QW; k++) begin : g_step
		localparam int BIT = QW - 1 - k;
		logic [RW-1:0] shd;
		logic          fits;
		assign shd  = RW'(den_s[k]) << BIT;
		assign fits = rem_s[k] >= shd;
		always_ff @(posedge clk) begin
			rem_s[k+1] <= fits ? rem_s[k] - shd : rem_s[k];
			den_s[k+1] <= den_s[k];
			quo_s[k+1] <= quo_s[k] | (fits ? (QW'(1) << BIT) : '0);
			ovf_s[k+1] <= ovf_s[k];
		end
	end

	assign quo = quo_s[QW];
	assign ovf = ovf_s[QW];

endmodule

// ----- sv/sprite_screen_projection.sv -----
// Top level of the sprite screen projection pipeline.
//
// Usage: pulse start with sprite_x/sprite_y while busy is low; busy stays low,
// so one sprite is taken every cycle. Each sprite yields exactly one result,
// shown for one cycle with done high, in the order the sprites came in.
// A sprite passes stages s1 to s6, the dividers, then p1 and p2 before done.
// Throughput is one sprite per clock; the four dividers are fully pipelined,
// one quotient bit per stage, and set the bulk of the latency.
// Camera registers are written over the cfg channel (cfg_ready always high)
// by the user only while no sprite is in flight; the block does not enforce it.
// Reset (arst_n low) loads the default camera and clears all valid bits, so
// nothing in flight survives. The receiver has no stall input: results are
// taken in the cycle they are shown. Index codes follow cfg_reg_t.
// degenerate=1 marks a zero determinant or zero depth; other fields are 0 then.
module sprite_screen_projection #(
	parameter int DISP_W = spsp_pkg::DEF_DISP_W,
	parameter int DISP_H = spsp_pkg::DEF_DISP_H
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [15:0]                       sprite_x,
	input  logic [15:0]                       sprite_y,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spsp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spsp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              done,
	output logic signed [15:0]                screen_column,
	output logic signed [23:0]                depth,
	output logic [14:0]                       height_px,
	output logic [9:0]                        start_row,
	output logic [9:0]                        end_row,
	output logic [14:0]                       width_px,
	output logic [14:0]                       start_col,
	output logic signed [15:0]                end_col,
	output logic                              degenerate
);
	import spsp_pkg::*;

	localparam int SWB = $clog2(DISP_W + 1);
	localparam int SHB = $clog2(DISP_H + 1);
	localparam int NCOLW = 35 + SWB;
	localparam int NHW   = 49 + SHB - 18;
	localparam int NWW   = 33 + SWB + 6;
	localparam int DLAT  = DIV_QW + 1;

	localparam logic [SWB-1:0] HALF_W = SWB'(DISP_W / 2);
	localparam logic [SWB-1:0] FULL_W = SWB'(DISP_W);
	localparam logic [SHB-1:0] FULL_H = SHB'(DISP_H);

	// ---------------- configuration registers ----------------
	logic [15:0] cam_pos_x_q, cam_pos_y_q, hscale_q, wscale_q;
	logic signed [15:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_pos_x_q <= RST_CAM_POS_X;
			cam_pos_y_q <= RST_CAM_POS_Y;
			dir_x_q     <= RST_CAM_DIR_X;
			dir_y_q     <= RST_CAM_DIR_Y;
			plane_x_q   <= RST_CAM_PLANE_X;
			plane_y_q   <= RST_CAM_PLANE_Y;
			hscale_q    <= RST_HEIGHT_SCALE;
			wscale_q    <= RST_WIDTH_SCALE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CAM_POS_X:    cam_pos_x_q <= cfg_data;
				REG_CAM_POS_Y:    cam_pos_y_q <= cfg_data;
				REG_CAM_DIR_X:    dir_x_q     <= cfg_data;
				REG_CAM_DIR_Y:    dir_y_q     <= cfg_data;
				REG_CAM_PLANE_X:  plane_x_q   <= cfg_data;
				REG_CAM_PLANE_Y:  plane_y_q   <= cfg_data;
				REG_HEIGHT_SCALE: hscale_q    <= cfg_data;
				REG_WIDTH_SCALE:  wscale_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- valid chain ----------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_p1;
	logic vld_d_q [DLAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_p1 <= 1'b0;
			done   <= 1'b0;
			for (int i = 0; i < DLAT; i++) vld_d_q[i] <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_d_q[0] <= vld_s6;
			for (int i = 1; i < DLAT; i++) vld_d_q[i] <= vld_d_q[i-1];
			vld_p1 <= vld_d_q[DLAT-1];
			done   <= vld_p1;
		end
	end

	// ---------------- s1: offsets from camera ----------------
	logic signed [16:0] dx_s1, dy_s1;
	always_ff @(posedge clk) begin
		dx_s1 <= $signed({1'b0, sprite_x}) - $signed({1'b0, cam_pos_x_q});
		dy_s1 <= $signed({1'b0, sprite_y}) - $signed({1'b0, cam_pos_y_q});
	end

	// ---------------- s2: partial products ----------------
	logic signed [32:0] p_dyx_s2, p_dxy_s2, p_pxy_s2, p_pyx_s2;
	logic signed [31:0] p_det1_s2, p_det2_s2;
	always_ff @(posedge clk) begin
		p_dyx_s2  <= 33'(dir_y_q) * 33'(dx_s1);
		p_dxy_s2  <= 33'(dir_x_q) * 33'(dy_s1);
		p_pxy_s2  <= 33'(plane_x_q) * 33'(dy_s1);
		p_pyx_s2  <= 33'(plane_y_q) * 33'(dx_s1);
		p_det1_s2 <= 32'(plane_x_q) * 32'(dir_y_q);
		p_det2_s2 <= 32'(plane_y_q) * 32'(dir_x_q);
	end

	// ---------------- s3: camera-space numerators and determinant ----------------
	logic signed [33:0] nx_s3, ny_s3;
	logic signed [32:0] det_s3;
	always_ff @(posedge clk) begin
		nx_s3  <= 34'(p_dyx_s2) - 34'(p_dxy_s2);
		ny_s3  <= 34'(p_pxy_s2) - 34'(p_pyx_s2);
		det_s3 <= 33'(p_det1_s2) - 33'(p_det2_s2);
	end

	// ---------------- s4: magnitudes ----------------
	logic signed [34:0] nxy_s4;
	logic [33:0] any_s4;
	logic [32:0] adet_s4;
	logic ny_neg_s4, det_neg_s4, det_zero_s4;
	always_ff @(posedge clk) begin
		nxy_s4      <= 35'(nx_s3) + 35'(ny_s3);
		any_s4      <= ny_s3[33] ? 34'(-ny_s3) : 34'(ny_s3);
		adet_s4     <= det_s3[32] ? 33'(-det_s3) : 33'(det_s3);
		ny_neg_s4   <= ny_s3[33];
		det_neg_s4  <= det_s3[32];
		det_zero_s4 <= (det_s3 == '0);
	end

	// ---------------- s5: scale products ----------------
	logic [34:0] anxy_s5;
	logic [33:0] any_s5;
	logic [32:0] adet_s5;
	logic [48:0] hsdet_s5;
	logic [49:0] nyws_s5;
	logic neg_dep_s5, neg_col_s5, det_zero_s5;
	always_ff @(posedge clk) begin
		anxy_s5     <= nxy_s4[34] ? 35'(-nxy_s4) : 35'(nxy_s4);
		any_s5      <= any_s4;
		adet_s5     <= adet_s4;
		hsdet_s5    <= 49'(hscale_q) * 49'(adet_s4);
		nyws_s5     <= 50'(any_s4) * 50'(wscale_q);
		neg_dep_s5  <= ny_neg_s4 ^ det_neg_s4;
		neg_col_s5  <= nxy_s4[34] ^ ny_neg_s4;
		det_zero_s5 <= det_zero_s4;
	end

	// ---------------- s6: divider operands ----------------
	logic [47:0] n_dep_s6;
	logic [NCOLW-1:0] n_col_s6;
	logic [NHW-1:0] n_h_s6;
	logic [NWW-1:0] n_w_s6;
	logic [49:0] d_w_s6;
	logic [33:0] any_s6;
	logic [32:0] adet_s6;
	logic neg_dep_s6, neg_col_s6, det_zero_s6, ws_zero_s6;
	logic [49+SHB-1:0] hfull;
	assign hfull = (49+SHB)'(hsdet_s5) * (49+SHB)'(FULL_H);
	always_ff @(posedge clk) begin
		n_dep_s6    <= 48'(any_s5) << 14;
		n_col_s6    <= NCOLW'(anxy_s5) * NCOLW'(HALF_W);
		n_h_s6      <= NHW'(hfull >> 18);
		n_w_s6      <= (NWW'(adet_s5) * NWW'(FULL_W)) << 6;
		d_w_s6      <= nyws_s5;
		any_s6      <= any_s5;
		adet_s6     <= adet_s5;
		neg_dep_s6  <= neg_dep_s5;
		neg_col_s6  <= neg_col_s5;
		det_zero_s6 <= det_zero_s5;
		ws_zero_s6  <= (wscale_q == '0);
	end

	// ---------------- dividers ----------------
	logic [DIV_QW-1:0] q_dep, q_col, q_h, q_w;
	logic ovf_dep, ovf_col, ovf_h, ovf_w;

	spsp_div #(.NW(48), .DW(33), .QW(DIV_QW)) u_div_dep (
		.clk(clk), .num(n_dep_s6), .den(adet_s6), .quo(q_dep), .ovf(ovf_dep));
	spsp_div #(.NW(NCOLW), .DW(34), .QW(DIV_QW)) u_div_col (
		.clk(clk), .num(n_col_s6), .den(any_s6), .quo(q_col), .ovf(ovf_col));
	spsp_div #(.NW(NHW), .DW(34), .QW(DIV_QW)) u_div_h (
		.clk(clk), .num(n_h_s6), .den(any_s6), .quo(q_h), .ovf(ovf_h));
	spsp_div #(.NW(NWW), .DW(50), .QW(DIV_QW)) u_div_w (
		.clk(clk), .num(n_w_s6), .den(d_w_s6), .quo(q_w), .ovf(ovf_w));

	// sideband flags delayed alongside the dividers
	logic [3:0] side_d_q [DLAT];
	always_ff @(posedge clk) begin
		side_d_q[0] <= {neg_dep_s6, neg_col_s6, det_zero_s6, ws_zero_s6};
		for (int i = 1; i < DLAT; i++) side_d_q[i] <= side_d_q[i-1];
	end

	// ---------------- p1: signs and saturation ----------------
	logic neg_dep, neg_col, det_zero, ws_zero;
	assign {neg_dep, neg_col, det_zero, ws_zero} = side_d_q[DLAT-1];

	logic signed [23:0] dep_c;
	logic signed [15:0] col_c;
	logic [14:0] h_c, w_c;
	logic dep_big, col_big;

	always_comb begin
		dep_big = ovf_dep || q_dep[23];
		if (neg_dep) dep_c = dep_big ? 24'sh800000 : 24'(-$signed({1'b0, q_dep[22:0]}));
		else         dep_c = dep_big ? 24'sh7FFFFF : $signed({1'b0, q_dep[22:0]});
		col_big = ovf_col || (q_col[DIV_QW-1:15] != '0);
		if (neg_col) col_c = col_big ? 16'sh8000 : 16'(-$signed({1'b0, q_col[14:0]}));
		else         col_c = col_big ? 16'sh7FFF : $signed({1'b0, q_col[14:0]});
		h_c = (ovf_h || (q_h[DIV_QW-1:15] != '0)) ? 15'h7FFF : q_h[14:0];
		w_c = (ws_zero || ovf_w || (q_w[DIV_QW-1:15] != '0)) ? 15'h7FFF : q_w[14:0];
	end

	logic signed [23:0] dep_p1;
	logic signed [15:0] col_p1;
	logic [14:0] h_p1, w_p1;
	logic degen_p1;
	always_ff @(posedge clk) begin
		dep_p1   <= dep_c;
		col_p1   <= col_c;
		h_p1     <= h_c;
		w_p1     <= w_c;
		degen_p1 <= det_zero || (dep_c == '0);
	end

	// ---------------- p2: draw bounds, output registers ----------------
	logic signed [17:0] srow, erow, scol, ecol;
	logic [9:0] srow_c, erow_c;
	always_comb begin
		srow = 18'(DISP_H / 2) - 18'(h_p1 >> 1);
		if (srow < 0) srow = '0;
		if (srow > 18'sd1023) srow = 18'sd1023;
		erow = 18'(h_p1 >> 1) + 18'(DISP_H / 2);
		if (erow >= 18'(DISP_H)) erow = 18'(DISP_H - 1);
		if (erow > 18'sd1023) erow = 18'sd1023;
		srow_c = srow[9:0];
		erow_c = erow[9:0];
		scol = 18'(col_p1) - 18'(w_p1 >> 1);
		if (scol < 0) scol = '0;
		ecol = 18'(col_p1) + 18'(w_p1 >> 1);
		if (ecol >= 18'(DISP_W)) ecol = 18'(DISP_W - 1);
	end

	always_ff @(posedge clk) begin
		degenerate <= degen_p1;
		if (degen_p1) begin
			screen_column <= '0;
			depth         <= '0;
			height_px     <= '0;
			start_row     <= '0;
			end_row       <= '0;
			width_px      <= '0;
			start_col     <= '0;
			end_col       <= '0;
		end else begin
			screen_column <= col_p1;
			depth         <= dep_p1;
			height_px     <= h_p1;
			start_row     <= srow_c;
			end_row       <= erow_c;
			width_px      <= w_p1;
			start_col     <= scol[14:0];
			end_col       <= ecol[15:0];
		end
	end

endmodule

// ----- sim/sprite_screen_projection_checker.sv -----
// Checker for the sprite screen projection block: predicts and compares each result.
`timescale 1ns / 1ps

module sprite_screen_projection_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [15:0]        sprite_x,
	input  logic [15:0]        sprite_y,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [spsp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               done,
	input  logic signed [15:0] screen_column,
	input  logic signed [23:0] depth,
	input  logic [14:0]        height_px,
	input  logic [9:0]         start_row,
	input  logic [9:0]         end_row,
	input  logic [14:0]        width_px,
	input  logic [14:0]        start_col,
	input  logic signed [15:0] end_col,
	input  logic               degenerate,
	output int                 fail_count,
	output int                 pending
);
	import spsp_pkg::*;

	typedef struct {
		logic signed [15:0] column;
		logic signed [23:0] dep;
		logic [14:0]        hgt;
		logic [9:0]         srow;
		logic [9:0]         erow;
		logic [14:0]        wid;
		logic [14:0]        scol;
		logic signed [15:0] ecol;
		logic               degen;
	} proj_t;

	logic [15:0] pos_x, pos_y, dir_x, dir_y, pl_x, pl_y, h_scale, w_scale;
	proj_t       projections[$];

	function automatic longint clampl(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic proj_t project(logic [15:0] sx, logic [15:0] sy);
		proj_t  p;
		longint dx, dy, dxs, dys, plxs, plys, det, nx, ny, dep, col, h, w;
		longint adet, any, q, srow, erow, scol, ecol;
		dx   = longint'(sx) - longint'(pos_x);
		dy   = longint'(sy) - longint'(pos_y);
		dxs  = longint'($signed(dir_x));
		dys  = longint'($signed(dir_y));
		plxs = longint'($signed(pl_x));
		plys = longint'($signed(pl_y));
		det  = plxs * dys - plys * dxs;
		nx   = dys * dx - dxs * dy;
		ny   = plxs * dy - plys * dx;
		dep  = 0;
		p = '{default: '0};
		if (det != 0)
			dep = clampl((ny * 16384) / det, -8388608, 8388607);
		if (det == 0 || dep == 0) begin
			p.degen = 1'b1;
			return p;
		end
		col  = clampl((longint'(DEF_DISP_W / 2) * (nx + ny)) / ny, -32768, 32767);
		adet = det < 0 ? -det : det;
		any  = ny < 0 ? -ny : ny;
		q    = (longint'(DEF_DISP_H) * longint'(h_scale) * adet) / (any <<< 18);
		h    = q > 32767 ? 32767 : q;
		if (w_scale == 0) begin
			w = 32767;
		end else begin
			q = (longint'(DEF_DISP_W) * adet * 64) / (any * longint'(w_scale));
			w = q > 32767 ? 32767 : q;
		end
		srow = clampl(DEF_DISP_H / 2 - h / 2, 0, 1023);
		erow = clampl(h / 2 + DEF_DISP_H / 2, 0, DEF_DISP_H - 1);
		erow = clampl(erow, 0, 1023);
		scol = col - w / 2;
		if (scol < 0)
			scol = 0;
		ecol = col + w / 2;
		if (ecol >= DEF_DISP_W)
			ecol = DEF_DISP_W - 1;
		p.column = col[15:0];
		p.dep    = dep[23:0];
		p.hgt    = h[14:0];
		p.srow   = srow[9:0];
		p.erow   = erow[9:0];
		p.wid    = w[14:0];
		p.scol   = scol[14:0];
		p.ecol   = ecol[15:0];
		return p;
	endfunction

	assign pending = projections.size();

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x   <= RST_CAM_POS_X;
			pos_y   <= RST_CAM_POS_Y;
			dir_x   <= RST_CAM_DIR_X;
			dir_y   <= RST_CAM_DIR_Y;
			pl_x    <= RST_CAM_PLANE_X;
			pl_y    <= RST_CAM_PLANE_Y;
			h_scale <= RST_HEIGHT_SCALE;
			w_scale <= RST_WIDTH_SCALE;
			fail_count <= 0;
			projections.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_CAM_POS_X:    pos_x   <= cfg_data;
					REG_CAM_POS_Y:    pos_y   <= cfg_data;
					REG_CAM_DIR_X:    dir_x   <= cfg_data;
					REG_CAM_DIR_Y:    dir_y   <= cfg_data;
					REG_CAM_PLANE_X:  pl_x    <= cfg_data;
					REG_CAM_PLANE_Y:  pl_y    <= cfg_data;
					REG_HEIGHT_SCALE: h_scale <= cfg_data;
					REG_WIDTH_SCALE:  w_scale <= cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				projections.push_back(project(sprite_x, sprite_y));
			if (done) begin
				if (projections.size() == 0) begin
					$error("unexpected result, nothing outstanding");
					fail_count <= fail_count + 1;
				end else begin
					proj_t e;
					int    bad;
					e = projections.pop_front();
					bad = 0;
					if (screen_column !== e.column) begin
						$error("screen_column exp %0d got %0d", e.column, screen_column); bad++;
					end
					if (depth !== e.dep) begin
						$error("depth exp %0d got %0d", e.dep, depth); bad++;
					end
					if (height_px !== e.hgt) begin
						$error("height_px exp %0d got %0d", e.hgt, height_px); bad++;
					end
					if (start_row !== e.srow) begin
						$error("start_row exp %0d got %0d", e.srow, start_row); bad++;
					end
					if (end_row !== e.erow) begin
						$error("end_row exp %0d got %0d", e.erow, end_row); bad++;
					end
					if (width_px !== e.wid) begin
						$error("width_px exp %0d got %0d", e.wid, width_px); bad++;
					end
					if (start_col !== e.scol) begin
						$error("start_col exp %0d got %0d", e.scol, start_col); bad++;
					end
					if (end_col !== e.ecol) begin
						$error("end_col exp %0d got %0d", e.ecol, end_col); bad++;
					end
					if (degenerate !== e.degen) begin
						$error("degenerate exp %0d got %0d", e.degen, degenerate); bad++;
					end
					fail_count <= fail_count + bad;
				end
			end
		end
	end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the sprite screen projection block: stimulus and verdict.
`timescale 1ns / 1ps

module tb;
	import spsp_pkg::*;

	// Settle time used before camera writes and at the end
	localparam int SETTLE    = 40;
	localparam int CYCLE_CAP = 200000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [15:0]        sprite_x = '0;
	logic [15:0]        sprite_y = '0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]        cfg_data = '0;
	logic               done;
	logic signed [15:0] screen_column;
	logic signed [23:0] depth;
	logic [14:0]        height_px;
	logic [9:0]         start_row;
	logic [9:0]         end_row;
	logic [14:0]        width_px;
	logic [14:0]        start_col;
	logic signed [15:0] end_col;
	logic               degenerate;
	int                 fail_count;
	int                 pending;
	int                 cycles = 0;
	int                 gap_pct = 0;
	// camera position currently programmed, so sprites can be placed near it
	logic [15:0]        eye_x = RST_CAM_POS_X;
	logic [15:0]        eye_y = RST_CAM_POS_Y;

	always #2 clk = ~clk;

	sprite_screen_projection dut (.*);

	sprite_screen_projection_checker checker_i (.*);

	// Run cap: a hung handshake or missing results end here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// One sprite transfer; optional random gap before it per gap_pct.
	task automatic send_sprite(input logic [15:0] x, input logic [15:0] y);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		sprite_x <= x;
		sprite_y <= y;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Camera writes happen only with the pipeline drained.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (r == REG_CAM_POS_X)
			eye_x = v;
		if (r == REG_CAM_POS_Y)
			eye_y = v;
	endtask

	task automatic set_camera(input logic [15:0] px, input logic [15:0] py,
			input logic [15:0] dx, input logic [15:0] dy,
			input logic [15:0] plx, input logic [15:0] ply,
			input logic [15:0] hs, input logic [15:0] ws);
		drain();
		write_reg(REG_CAM_POS_X, px);
		write_reg(REG_CAM_POS_Y, py);
		write_reg(REG_CAM_DIR_X, dx);
		write_reg(REG_CAM_DIR_Y, dy);
		write_reg(REG_CAM_PLANE_X, plx);
		write_reg(REG_CAM_PLANE_Y, ply);
		write_reg(REG_HEIGHT_SCALE, hs);
		write_reg(REG_WIDTH_SCALE, ws);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Unit-ish dir, perpendicular plane, random scales; 1 in 4 all random.
	task automatic random_camera();
		logic [15:0] a, b;
		int          k;
		a = 16'($urandom_range(0, 16384));
		b = 16'($urandom_range(0, 16384));
		if ($urandom_range(1)) a = -a;
		if ($urandom_range(1)) b = -b;
		k = $urandom_range(3);
		if (k == 0)
			set_camera(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom_range(1, 65535)));
		else
			set_camera(16'($urandom), 16'($urandom), a, b, -b, a,
				16'($urandom_range(0, 16384)), 16'($urandom_range(1, 16384)));
	endtask

	// Mostly sprites within a few map units of the camera, where sizes and
	// bounds are interesting; the rest anywhere in the world.
	task automatic random_sprites(input int n);
		logic [15:0] x, y;
		repeat (n) begin
			if ($urandom_range(9) < 7) begin
				x = eye_x + 16'($signed(12'($urandom)));
				y = eye_y + 16'($signed(12'($urandom)));
			end else begin
				x = 16'($urandom);
				y = 16'($urandom);
			end
			send_sprite(x, y);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset camera at origin looking down +x.
		send_sprite(16'd0, 16'd0);          // on the camera: zero depth
		send_sprite(16'd1, 16'd0);          // tiny depth: oversized sizes saturate
		send_sprite(16'd256, 16'd0);
		send_sprite(16'd256, 16'd256);
		send_sprite(16'd256, 16'd65535);
		send_sprite(16'd65535, 16'd0);
		send_sprite(16'd65535, 16'd65535);
		send_sprite(16'd0, 16'd65535);      // beside the camera: zero depth
		send_sprite(16'd4096, 16'd1024);
		send_sprite(16'd2, 16'd300);        // column far off screen

		// Zero determinant.
		set_camera(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd4096, 16'd4096);
		send_sprite(16'd100, 16'd200);
		send_sprite(16'd65535, 16'd65535);

		// Extremes of every register.
		set_camera(16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
			16'hFFFF, 16'd1);
		send_sprite(16'd0, 16'd0);
		send_sprite(16'hFFFF, 16'd0);
		send_sprite(16'd0, 16'hFFFF);
		send_sprite(16'hFFFE, 16'hFFFD);
		set_camera(16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF,
			16'd0, 16'hFFFF);
		send_sprite(16'h8100, 16'h8000);
		send_sprite(16'h0000, 16'hFFFF);
		send_sprite(16'hFFFF, 16'h0000);
		send_sprite(16'h7F00, 16'h8000);    // behind the camera: negative depth

		// Random part: sender gaps 38%, then 56%, then back to back.
		for (int ph = 0; ph < 12; ph++) begin
			gap_pct = ph < 4 ? 38 : (ph < 8 ? 56 : 0);
			random_camera();
			random_sprites(125);
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
